// ----- hdl/wrh_pkg.sv -----
// ----------------------------------------------------------------------------
// wrh_pkg
// Shared types and codes of the water ripple height field unit.
// ----------------------------------------------------------------------------
package wrh_pkg;

   localparam int MIN_DIM = 3;

   localparam logic [1:0] CMD_DROP  = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [3:0] CSR_GRID_WIDTH  = 4'd0;
   localparam logic [3:0] CSR_GRID_HEIGHT = 4'd1;

   localparam logic [4:0] OP_NOP      = 5'd0;
   localparam logic [4:0] OP_LATCH    = 5'd1;
   localparam logic [4:0] OP_DISP     = 5'd2;
   localparam logic [4:0] OP_CLR      = 5'd3;
   localparam logic [4:0] OP_DROP     = 5'd4;
   localparam logic [4:0] OP_ST_BEGIN = 5'd5;
   localparam logic [4:0] OP_STA      = 5'd6;
   localparam logic [4:0] OP_STB      = 5'd7;
   localparam logic [4:0] OP_STC      = 5'd8;
   localparam logic [4:0] OP_STD      = 5'd9;
   localparam logic [4:0] OP_STE      = 5'd10;
   localparam logic [4:0] OP_SWAP     = 5'd11;
   localparam logic [4:0] OP_SUM      = 5'd12;
   localparam logic [4:0] OP_SUM_TAIL = 5'd13;
   localparam logic [4:0] OP_QA       = 5'd14;
   localparam logic [4:0] OP_QB       = 5'd15;
   localparam logic [4:0] OP_QC       = 5'd16;
   localparam logic [4:0] OP_QD       = 5'd17;
   localparam logic [4:0] OP_RESPOND  = 5'd18;

   typedef struct packed {
      logic [1:0] cmd;
      logic [6:0] col;
      logic [6:0] row;
   } req_type;

   typedef struct packed {
      logic       active;
      logic       accepted;
      logic [6:0] src_col;
      logic [6:0] src_row;
      logic       src_valid;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       fits;
      logic       active;
      logic       drop_last;
      logic       cell_last;
      logic       cnt_last;
      logic       sums_eq;
      logic       rsp_busy;
   } dp_stat_type;

endpackage

// ----- hdl/water_ripple_height_field_unit.sv -----
// ----------------------------------------------------------------------------
// water_ripple_height_field_unit
// Two-bank wave height field: stone drop, wave step with damping, query.
// ----------------------------------------------------------------------------
//  channel  ports              moves
//  req      req_valid/ready    one command word (cmd, col, row)
//  rsp      rsp_valid/ready    one result word per command
//  csr      csr_valid/ready    register index and 8-bit data
//
//  Drop sweeps 4*R*R stone offsets. An idle step or an unused command goes
//  straight to the reply. Step: a pass over the interior cells, then a sum sweep
//  of one RAM word per cycle, 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) words.
//  Equal sums add a clearing sweep over all RAM words before the reply.
//  Reset and each grid width or height register write start a clearing sweep
//  over all RAM words; commands wait for it, register writes are still taken.
//  A result that waits in the output register stalls only the next reply.
// ----------------------------------------------------------------------------
module water_ripple_height_field_unit import wrh_pkg::*; #(
   parameter int MAX_WIDTH    = 128,
   parameter int MAX_HEIGHT   = 128,
   parameter int HEIGHT_BITS  = 16,
   parameter int STONE_RADIUS = 10,
   parameter int STONE_DEPTH  = 50
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_index,
   input  logic [7:0] csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        csr_hit;

   assign csr_hit = csr_valid && csr_ready &&
                    ((csr_index == CSR_GRID_WIDTH) || (csr_index == CSR_GRID_HEIGHT));

   wrh_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_hit(csr_hit),
      .stat(stat), .cmd(cmd)
   );

   wrh_dp #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .HEIGHT_BITS(HEIGHT_BITS),
      .STONE_RADIUS(STONE_RADIUS), .STONE_DEPTH(STONE_DEPTH)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .csr_hit(csr_hit),
      .csr_index(csr_index), .csr_data(csr_data), .req_data(req_data),
      .rsp_ready(rsp_ready), .stat(stat), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word taken while busy");
   a_src_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.src_valid) |-> !rsp_data.accepted)
      else $error("query result marked accepted");
   a_src_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.src_valid) |->
      (rsp_data.src_col == 7'd0 && rsp_data.src_row == 7'd0))
      else $error("source coordinates without valid");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && (csr_valid && csr_ready)))
      else $error("command and register write taken together");
`endif

endmodule

// ----- hdl/wrh_ram.sv -----
// ----------------------------------------------------------------------------
// wrh_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module wrh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wa,
   input  logic [WIDTH-1:0]         wd,
   input  logic [$clog2(DEPTH)-1:0] ra,
   input  logic [$clog2(DEPTH)-1:0] rb,
   output logic [WIDTH-1:0]         da,
   output logic [WIDTH-1:0]         db
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      da <= mem[ra];
      db <= mem[rb];
   end

endmodule

// ----- hdl/wrh_ctrl.sv -----
// ----------------------------------------------------------------------------
// wrh_ctrl
// Sequencer: clear sweep, drop sweep, step sweep, sum sweep, query, reply.
// ----------------------------------------------------------------------------
module wrh_ctrl import wrh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_hit,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_DISP     = 5'd2;
   localparam logic [4:0] S_DROP     = 5'd3;
   localparam logic [4:0] S_ST_BEGIN = 5'd4;
   localparam logic [4:0] S_STA      = 5'd5;
   localparam logic [4:0] S_STB      = 5'd6;
   localparam logic [4:0] S_STC      = 5'd7;
   localparam logic [4:0] S_STD      = 5'd8;
   localparam logic [4:0] S_STE      = 5'd9;
   localparam logic [4:0] S_SWAP     = 5'd10;
   localparam logic [4:0] S_SUM      = 5'd11;
   localparam logic [4:0] S_SUM_TAIL = 5'd12;
   localparam logic [4:0] S_SUM_CHK  = 5'd13;
   localparam logic [4:0] S_QA       = 5'd14;
   localparam logic [4:0] S_QB       = 5'd15;
   localparam logic [4:0] S_QC       = 5'd16;
   localparam logic [4:0] S_QD       = 5'd17;
   localparam logic [4:0] S_DONE     = 5'd18;

   logic [4:0] state_ff, state_in;
   logic       pend_ff, pend_in;

   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      cmd.op    = OP_NOP;
      req_ready = 1'b0;
      csr_ready = (state_ff == S_IDLE) || (state_ff == S_CLEAR);
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLR;
            if (!csr_hit && stat.cnt_last) begin
               state_in = pend_ff ? S_DONE : S_IDLE;
               pend_in  = 1'b0;
            end
         end
         S_IDLE: begin
            req_ready = !csr_valid;
            if (csr_hit) begin
               state_in = S_CLEAR;
            end else if (req_valid && !csr_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            cmd.op = OP_DISP;
            unique case (stat.cmd)
               CMD_DROP:  state_in = stat.fits ? S_DROP : S_DONE;
               CMD_STEP:  state_in = stat.active ? S_ST_BEGIN : S_DONE;
               CMD_QUERY: state_in = S_QA;
               default:   state_in = S_DONE;
            endcase
         end
         S_DROP: begin
            cmd.op = OP_DROP;
            if (stat.drop_last) begin
               state_in = S_DONE;
            end
         end
         S_ST_BEGIN: begin
            cmd.op   = OP_ST_BEGIN;
            state_in = S_STA;
         end
         S_STA: begin
            cmd.op   = OP_STA;
            state_in = S_STB;
         end
         S_STB: begin
            cmd.op   = OP_STB;
            state_in = S_STC;
         end
         S_STC: begin
            cmd.op   = OP_STC;
            state_in = S_STD;
         end
         S_STD: begin
            cmd.op   = OP_STD;
            state_in = S_STE;
         end
         S_STE: begin
            cmd.op   = OP_STE;
            state_in = stat.cell_last ? S_SWAP : S_STA;
         end
         S_SWAP: begin
            cmd.op   = OP_SWAP;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op = OP_SUM;
            if (stat.cnt_last) begin
               state_in = S_SUM_TAIL;
            end
         end
         S_SUM_TAIL: begin
            cmd.op   = OP_SUM_TAIL;
            state_in = S_SUM_CHK;
         end
         S_SUM_CHK: begin
            if (stat.sums_eq) begin
               pend_in  = 1'b1;
               state_in = S_CLEAR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_QA: begin
            cmd.op   = OP_QA;
            state_in = S_QB;
         end
         S_QB: begin
            cmd.op   = OP_QB;
            state_in = S_QC;
         end
         S_QC: begin
            cmd.op   = OP_QC;
            state_in = S_QD;
         end
         S_QD: begin
            cmd.op   = OP_QD;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ----- hdl/wrh_dp.sv -----
// ----------------------------------------------------------------------------
// wrh_dp
// Datapath: height banks, sweep counters, wave update, damping, sums, query.
// ----------------------------------------------------------------------------
module wrh_dp import wrh_pkg::*; #(
   parameter int MAX_WIDTH    = 128,
   parameter int MAX_HEIGHT   = 128,
   parameter int HEIGHT_BITS  = 16,
   parameter int STONE_RADIUS = 10,
   parameter int STONE_DEPTH  = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  logic        csr_hit,
   input  logic [3:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  req_type     req_data,
   input  logic        rsp_ready,
   output dp_stat_type stat,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int CB    = $clog2(MAX_WIDTH);
   localparam int RB    = $clog2(MAX_HEIGHT);
   localparam int AW    = CB + RB;
   localparam int DEPTH = 1 << AW;
   localparam int HB    = HEIGHT_BITS;
   localparam int R     = STONE_RADIUS;
   localparam int KW    = $clog2(MAX_WIDTH + MAX_HEIGHT + 4 * STONE_RADIUS + 256) + 1;
   localparam int DB    = $clog2(2 * STONE_RADIUS);
   localparam int DW    = DB + 2;
   localparam int NW    = HB + KW + 2;

   function automatic logic [AW-1:0] addr_of(input logic [KW-1:0] r, input logic [KW-1:0] c);
      return {r[RB-1:0], c[CB-1:0]};
   endfunction

   function automatic logic [31:0] abs32(input logic [HB-1:0] d);
      logic signed [32:0] e;
      e = 33'($signed(d));
      if (e < 0) begin
         e = -e;
      end
      return e[31:0];
   endfunction

   logic [7:0]          gw_ff, gw_in, gh_ff, gh_in;
   logic                cb_ff, cb_in, act_ff, act_in;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic [DB-1:0]       ox_ff, ox_in, oy_ff, oy_in;
   logic [KW-1:0]       rc_ff, rc_in, cc_ff, cc_in;
   req_type             item_ff, item_in;
   logic                acc_ff, acc_in;
   logic signed [HB-1:0] l_ff, l_in, r_ff, r_in, u_ff, u_in, d_ff, d_in;
   logic signed [HB-1:0] p_ff, p_in, v_ff, v_in;
   logic                sv_ff, sv_in;
   logic [31:0]         s1_ff, s1_in, s2_ff, s2_in;
   logic [6:0]          qc_ff, qc_in, qr_ff, qr_in;
   logic                qv_ff, qv_in;
   logic                rspv_ff, rspv_in;
   rsp_type             rspd_ff, rspd_in;

   logic [KW-1:0] w, h, x, y, px, py, gwk, ghk;
   logic          fits, in_disk, interior;
   logic signed [DW-1:0]   dx, dy;
   logic signed [2*DW:0]   rad_sq;
   logic signed [HB+1:0]   hsum;
   logic signed [HB-1:0]   vn, np;
   logic [7:0]             cand, sub8;
   logic                   found;
   logic signed [NW-1:0]   xn, yn, wn, hn, nx, ny;
   logic                   qpre;

   logic [AW-1:0] cur_ra, cur_rb, prv_ra, cur_wa, prv_wa;
   logic          cur_we, prv_we;
   logic [HB-1:0] cur_wd, prv_wd, cur_da, cur_db, prv_da;
   logic [AW-1:0] b0_wa, b1_wa, b0_ra, b1_ra;
   logic          b0_we, b1_we;
   logic [HB-1:0] b0_wd, b1_wd, b0_a, b0_b, b1_a, b1_b;

   always_comb begin
      gwk = KW'(gw_ff);
      ghk = KW'(gh_ff);
      if (gwk < KW'(MIN_DIM)) w = KW'(MIN_DIM);
      else if (gwk > KW'(MAX_WIDTH)) w = KW'(MAX_WIDTH);
      else w = gwk;
      if (ghk < KW'(MIN_DIM)) h = KW'(MIN_DIM);
      else if (ghk > KW'(MAX_HEIGHT)) h = KW'(MAX_HEIGHT);
      else h = ghk;
      x = KW'(item_ff.col);
      y = KW'(item_ff.row);
      fits = (x >= KW'(R)) && (y >= KW'(R)) && (x + KW'(R) <= w) && (y + KW'(R) <= h);
      px = x + KW'(ox_ff) - KW'(R);
      py = y + KW'(oy_ff) - KW'(R);
      dx = $signed({2'b00, ox_ff}) - $signed(DW'(R));
      dy = $signed({2'b00, oy_ff}) - $signed(DW'(R));
      rad_sq = dx * dx + dy * dy;
      in_disk = rad_sq < $signed((2*DW+1)'(R * R));
      interior = (px != '0) && (py != '0) && (px + KW'(1) < w) && (py + KW'(1) < h);
      hsum = (HB+2)'(l_ff) + (HB+2)'(r_ff) + (HB+2)'(u_ff) + (HB+2)'(d_ff);
      vn = HB'((hsum >>> 1) - (HB+2)'(p_ff));
      sub8 = '0;
      found = 1'b0;
      for (int k = 5; k >= 0; k--) begin
         cand = 8'(v_ff >>> k);
         if (!found && cand != '0) begin
            sub8  = cand;
            found = 1'b1;
         end
      end
      np = v_ff - HB'($signed(sub8));
      xn = NW'($signed({1'b0, x}));
      yn = NW'($signed({1'b0, y}));
      wn = NW'($signed({1'b0, w}));
      hn = NW'($signed({1'b0, h}));
      nx = xn + NW'(l_ff) - NW'(r_ff);
      ny = yn + NW'(u_ff) - NW'(d_ff);
      qpre = (x < w) && (y >= KW'(1)) && (y + KW'(1) < h);
   end

   always_comb begin
      cur_ra = '0;
      cur_rb = '0;
      prv_ra = addr_of(rc_ff, cc_ff);
      cur_we = 1'b0;
      prv_we = 1'b0;
      cur_wa = cnt_ff;
      prv_wa = cnt_ff;
      cur_wd = '0;
      prv_wd = '0;
      unique case (cmd.op)
         OP_CLR: begin
            cur_we = 1'b1;
            prv_we = 1'b1;
         end
         OP_DROP: begin
            cur_we = in_disk && interior;
            cur_wa = addr_of(py, px);
            cur_wd = HB'(-STONE_DEPTH);
         end
         OP_STA: begin
            cur_ra = addr_of(rc_ff, cc_ff - KW'(1));
            cur_rb = addr_of(rc_ff, cc_ff + KW'(1));
         end
         OP_STB: begin
            cur_ra = addr_of(rc_ff - KW'(1), cc_ff);
            cur_rb = addr_of(rc_ff + KW'(1), cc_ff);
         end
         OP_STE: begin
            prv_we = 1'b1;
            prv_wa = addr_of(rc_ff, cc_ff);
            prv_wd = np;
         end
         OP_SUM: begin
            cur_ra = cnt_ff;
            prv_ra = cnt_ff;
         end
         OP_QA: begin
            cur_ra = addr_of(y, x - KW'(1));
            cur_rb = addr_of(y, x + KW'(1));
         end
         OP_QB: begin
            cur_ra = addr_of(y - KW'(1), x);
            cur_rb = addr_of(y + KW'(1), x);
         end
         default: begin
         end
      endcase
   end

   assign b0_we  = cb_ff ? prv_we : cur_we;
   assign b0_wa  = cb_ff ? prv_wa : cur_wa;
   assign b0_wd  = cb_ff ? prv_wd : cur_wd;
   assign b0_ra  = cb_ff ? prv_ra : cur_ra;
   assign b1_we  = cb_ff ? cur_we : prv_we;
   assign b1_wa  = cb_ff ? cur_wa : prv_wa;
   assign b1_wd  = cb_ff ? cur_wd : prv_wd;
   assign b1_ra  = cb_ff ? cur_ra : prv_ra;
   assign cur_da = cb_ff ? b1_a : b0_a;
   assign cur_db = cb_ff ? b1_b : b0_b;
   assign prv_da = cb_ff ? b0_a : b1_a;

   wrh_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_bank0 (
      .clock(clock), .we(b0_we), .wa(b0_wa), .wd(b0_wd),
      .ra(b0_ra), .rb(cur_rb), .da(b0_a), .db(b0_b)
   );

   wrh_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_bank1 (
      .clock(clock), .we(b1_we), .wa(b1_wa), .wd(b1_wd),
      .ra(b1_ra), .rb(cur_rb), .da(b1_a), .db(b1_b)
   );

   always_comb begin
      gw_in = gw_ff;   gh_in = gh_ff;   cb_in = cb_ff;   act_in = act_ff;
      cnt_in = cnt_ff; ox_in = ox_ff;   oy_in = oy_ff;   rc_in = rc_ff;
      cc_in = cc_ff;   item_in = item_ff; acc_in = acc_ff;
      l_in = l_ff;     r_in = r_ff;     u_in = u_ff;     d_in = d_ff;
      p_in = p_ff;     v_in = v_ff;     sv_in = sv_ff;   s1_in = s1_ff;
      s2_in = s2_ff;   qc_in = qc_ff;   qr_in = qr_ff;   qv_in = qv_ff;
      rspv_in = rspv_ff; rspd_in = rspd_ff;
      if (rspv_ff && rsp_ready) begin
         rspv_in = 1'b0;
      end
      unique case (cmd.op)
         OP_LATCH: begin
            item_in = req_data;
            ox_in = '0; oy_in = '0;
            acc_in = 1'b0; qc_in = '0; qr_in = '0; qv_in = 1'b0;
         end
         OP_DISP: begin
            acc_in = ((item_ff.cmd == CMD_DROP) && fits) ||
                     ((item_ff.cmd == CMD_STEP) && act_ff);
         end
         OP_CLR: begin
            cnt_in = cnt_ff + AW'(1);
            cb_in = 1'b0;
            act_in = 1'b0;
         end
         OP_DROP: begin
            if (in_disk && interior) begin
               act_in = 1'b1;
            end
            if (ox_ff == DB'(2 * R - 1)) begin
               ox_in = '0;
               oy_in = oy_ff + DB'(1);
            end else begin
               ox_in = ox_ff + DB'(1);
            end
         end
         OP_ST_BEGIN: begin
            act_in = 1'b0;
            rc_in = KW'(1);
            cc_in = KW'(1);
         end
         OP_STB: begin
            l_in = cur_da;
            r_in = cur_db;
         end
         OP_STC: begin
            u_in = cur_da;
            d_in = cur_db;
            p_in = prv_da;
         end
         OP_STD: begin
            v_in = vn;
         end
         OP_STE: begin
            if (np != '0) begin
               act_in = 1'b1;
            end
            if (cc_ff + KW'(2) == w) begin
               cc_in = KW'(1);
               rc_in = rc_ff + KW'(1);
            end else begin
               cc_in = cc_ff + KW'(1);
            end
         end
         OP_SWAP: begin
            cb_in = !cb_ff;
            cnt_in = '0;
            sv_in = 1'b0;
            s1_in = '0;
            s2_in = '0;
         end
         OP_SUM: begin
            cnt_in = cnt_ff + AW'(1);
            sv_in = 1'b1;
            if (sv_ff) begin
               s1_in = s1_ff + abs32(cur_da);
               s2_in = s2_ff + abs32(prv_da);
            end
         end
         OP_SUM_TAIL: begin
            s1_in = s1_ff + abs32(cur_da);
            s2_in = s2_ff + abs32(prv_da);
            sv_in = 1'b0;
            cnt_in = '0;
         end
         OP_QB: begin
            l_in = (x != '0) ? $signed(cur_da) : '0;
            r_in = (x + KW'(1) < w) ? $signed(cur_db) : '0;
         end
         OP_QC: begin
            u_in = cur_da;
            d_in = cur_db;
         end
         OP_QD: begin
            if (qpre && nx >= 0 && nx < wn && ny >= 0 && ny < hn) begin
               qc_in = nx[6:0];
               qr_in = ny[6:0];
               qv_in = 1'b1;
            end
         end
         OP_RESPOND: begin
            rspv_in = 1'b1;
            rspd_in.active    = act_ff;
            rspd_in.accepted  = acc_ff;
            rspd_in.src_col   = qc_ff;
            rspd_in.src_row   = qr_ff;
            rspd_in.src_valid = qv_ff;
         end
         default: begin
         end
      endcase
      if (csr_hit) begin
         cnt_in = '0;
         if (csr_index == CSR_GRID_WIDTH) gw_in = csr_data;
         if (csr_index == CSR_GRID_HEIGHT) gh_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff   <= 8'd128;
         gh_ff   <= 8'd128;
         cb_ff   <= 1'b0;
         act_ff  <= 1'b0;
         cnt_ff  <= '0;
         sv_ff   <= 1'b0;
         rspv_ff <= 1'b0;
      end else begin
         gw_ff   <= gw_in;
         gh_ff   <= gh_in;
         cb_ff   <= cb_in;
         act_ff  <= act_in;
         cnt_ff  <= cnt_in;
         sv_ff   <= sv_in;
         rspv_ff <= rspv_in;
      end
      ox_ff <= ox_in;   oy_ff <= oy_in;   rc_ff <= rc_in;   cc_ff <= cc_in;
      item_ff <= item_in; acc_ff <= acc_in;
      l_ff <= l_in;     r_ff <= r_in;     u_ff <= u_in;     d_ff <= d_in;
      p_ff <= p_in;     v_ff <= v_in;     s1_ff <= s1_in;   s2_ff <= s2_in;
      qc_ff <= qc_in;   qr_ff <= qr_in;   qv_ff <= qv_in;   rspd_ff <= rspd_in;
   end

   always_comb begin
      stat.cmd       = item_ff.cmd;
      stat.fits      = fits;
      stat.active    = act_ff;
      stat.drop_last = (ox_ff == DB'(2 * R - 1)) && (oy_ff == DB'(2 * R - 1));
      stat.cell_last = (cc_ff + KW'(2) == w) && (rc_ff + KW'(2) == h);
      stat.cnt_last  = &cnt_ff;
      stat.sums_eq   = s1_ff == s2_ff;
      stat.rsp_busy  = rspv_ff && !rsp_ready;
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data  = rspd_ff;

endmodule
